// ----- src/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types and fixed codes for the character-cell console engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    // Console commands carried on the input side
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // Control bytes and cell defaults
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h17;

    // Port payload widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

endpackage

`default_nettype wire

// ----- src/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell screen store with cursor, put/clear/read commands and scroll.
// ----------------------------------------------------------------------------
// Flow: put (no scroll), read and no-op go from the accepting cycle to ST_RESP,
//   which loads the result register once it is free; one beat in flight, so no new item is taken before that.
// A put that scrolls passes through ST_SCROLL: one cell copy per cycle through the
//   screen memory's separate read and write ports. Clear passes through ST_CLEAR.
// Reset: synchronous, active low; then a clearing pass in ST_INIT fills the store
//   with spaces in attribute 0x17 while s_tready stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration: text_attribute
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [7:0]                       cfg_data,
    // input beat
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata: character [7:0], cell_index [18:8], zero [23:19]
    input  wire logic [tcce_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: command [1:0]
    input  wire logic [1:0]                       s_tuser,
    // result beat
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata: cell_char [7:0], cell_attr [15:8], cursor_col [22:16],
    //        cursor_row [27:23], cursor_position [38:28], zero [39]
    output logic [tcce_pkg::OUT_DATA_W-1:0]       m_tdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CSUM_W     = $clog2(COLUMNS + TAB_STEP);
    localparam int RSUM_W     = ROW_W + 1;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int SHIFT_LAST = CELL_COUNT - COLUMNS;

    tcce_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        attr_reg, attr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic [tcce_pkg::OUT_DATA_W-1:0] out_reg, out_next;

    // screen memory port
    logic [15:0]       screen_mem [CELL_COUNT];
    logic [15:0]       mem_q_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    // input fields
    tcce_pkg::cmd_t    in_cmd;
    logic [7:0]        in_char;
    logic [10:0]       in_idx;
    logic              idx_ok;
    logic              accept;

    // put path
    logic [AW-1:0]     pos;
    logic [CSUM_W-1:0] col_sum;
    logic [RSUM_W-1:0] row_sum;
    logic              put_we;
    logic [AW-1:0]     put_waddr;
    logic [15:0]       put_wdata;
    logic              scroll_req;
    logic [15:0]       cell_out;

    assign in_cmd   = tcce_pkg::cmd_t'(s_tuser);
    assign in_char  = s_tdata[7:0];
    assign in_idx   = s_tdata[18:8];
    assign idx_ok   = 32'(in_idx) < CELL_COUNT;
    assign s_tready = (state_reg == tcce_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign pos      = AW'(row_reg * COLUMNS + col_reg);

    // Decode one put byte into a cell write and the new cursor
    always_comb begin
        col_sum   = CSUM_W'(col_reg);
        row_sum   = RSUM_W'(row_reg);
        put_we    = 1'b0;
        put_waddr = pos;
        put_wdata = {attr_reg, in_char};
        unique case (in_char) inside
            tcce_pkg::CHAR_LF, tcce_pkg::CHAR_CR: begin
                col_sum = '0;
                row_sum = row_sum + 1'b1;
            end
            tcce_pkg::CHAR_BS: begin
                put_we    = 1'b1;
                put_wdata = {attr_reg, tcce_pkg::CHAR_SPACE};
                put_waddr = (pos == '0) ? '0 : pos - AW'(1);
                if (col_reg == '0) begin
                    if (row_reg != '0) begin
                        row_sum = RSUM_W'(row_reg) - 1'b1;
                        col_sum = CSUM_W'(COLUMNS - 1);
                    end
                end else begin
                    col_sum = CSUM_W'(col_reg) - 1'b1;
                end
            end
            tcce_pkg::CHAR_TAB: begin
                col_sum = CSUM_W'(col_reg) + CSUM_W'(TAB_STEP);
            end
            default: begin
                put_we  = 1'b1;
                col_sum = CSUM_W'(col_reg) + 1'b1;
            end
        endcase
        // wrap a full row
        if (col_sum > CSUM_W'(COLUMNS - 1)) begin
            col_sum = '0;
            row_sum = row_sum + 1'b1;
        end
        scroll_req = row_sum > RSUM_W'(ROWS - 1);
    end

    assign cell_out = rd_ok_reg ? mem_q_reg : 16'd0;

    // Sequencer: next state, memory port and result register
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        attr_next    = attr_reg;
        rd_ok_next   = rd_ok_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = cnt_reg[AW-1:0];
        mem_wdata    = {attr_reg, tcce_pkg::CHAR_SPACE};
        mem_raddr    = AW'(in_idx);

        if (cfg_valid) begin
            attr_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            tcce_pkg::ST_INIT, tcce_pkg::ST_CLEAR: begin
                // fill one cell per cycle with blanks; reset fill uses the reset attribute
                mem_we   = 1'b1;
                if (state_reg == tcce_pkg::ST_INIT) begin
                    mem_wdata = {tcce_pkg::RESET_ATTR, tcce_pkg::CHAR_SPACE};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = (state_reg == tcce_pkg::ST_INIT) ?
                                 tcce_pkg::ST_IDLE : tcce_pkg::ST_RESP;
                end
            end
            tcce_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    rd_ok_next = 1'b0;
                    cnt_next   = '0;
                    unique case (in_cmd)
                        tcce_pkg::CMD_PUT: begin
                            mem_we     = put_we;
                            mem_waddr  = put_waddr;
                            mem_wdata  = put_wdata;
                            col_next   = COL_W'(col_sum);
                            row_next   = scroll_req ? ROW_W'(ROWS - 1) : ROW_W'(row_sum);
                            state_next = scroll_req ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_RESP;
                        end
                        tcce_pkg::CMD_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = tcce_pkg::ST_CLEAR;
                        end
                        tcce_pkg::CMD_READ: begin
                            mem_re     = idx_ok;
                            rd_ok_next = idx_ok;
                            state_next = tcce_pkg::ST_RESP;
                        end
                        tcce_pkg::CMD_NOP: begin
                            state_next = tcce_pkg::ST_RESP;
                        end
                        default: begin
                            state_next = tcce_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            tcce_pkg::ST_SCROLL: begin
                // read cell k+COLUMNS, write back the cell read last cycle to k-1
                mem_re    = 32'(cnt_reg) < SHIFT_LAST;
                mem_raddr = AW'(32'(cnt_reg) + COLUMNS);
                mem_we    = (cnt_reg != '0);
                mem_waddr = AW'(cnt_reg - 1'b1);
                mem_wdata = (32'(cnt_reg) <= SHIFT_LAST) ? mem_q_reg : 16'd0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELL_COUNT)) begin
                    cnt_next   = '0;
                    state_next = tcce_pkg::ST_RESP;
                end
            end
            tcce_pkg::ST_RESP: begin
                // load the result beat once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_next     = {1'b0, 11'(pos), 5'(row_reg), 7'(col_reg),
                                    cell_out[15:8], cell_out[7:0]};
                    state_next   = tcce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcce_pkg::ST_INIT;
            cnt_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            attr_reg    <= tcce_pkg::RESET_ATTR;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            attr_reg    <= attr_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // Screen memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= screen_mem[mem_raddr];
        end
    end

    // Checks
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(row_reg) < ROWS) && (32'(col_reg) < COLUMNS))
        else $error("cursor outside the screen");

    a_scroll_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcce_pkg::ST_SCROLL) |-> (32'(cnt_reg) <= CELL_COUNT))
        else $error("scroll counter overran the store");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcce_pkg::ST_IDLE && !accept) |-> !mem_we)
        else $error("screen written while idle");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == tcce_pkg::ST_RESP))
        else $error("result beat raised outside the response step");

    a_read_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd != tcce_pkg::CMD_READ) |=> !rd_ok_reg)
        else $error("cell data kept for a non-read command");

endmodule

`default_nettype wire
